// ===== sv/mfps_pkg.sv =====
package mfps_pkg;

  // Defaults handed to the top-level parameters
  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned SUM_BITS_DEF   = 32;

  // Fixed widths of the ports
  localparam int unsigned OUT_BITS     = 32;
  localparam int unsigned CFG_BITS     = 11;
  localparam int unsigned CFG_IDX_BITS = 2;

  // Row limit and row counter width
  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned ROW_BITS = $clog2(MAX_ROWS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } cfg_reg_e;

  // Position flags of one element as it moves into the compute stage
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic has_left;
    logic has_right;
    logic last_col;
    logic single_col;
  } item_flags_t;

  function automatic int unsigned addr_bits(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // Clamp a size register to 1..limit and return size minus one
  function automatic int unsigned clamp_last(logic [CFG_BITS-1:0] v, int unsigned limit);
    int unsigned r;
    r = 0;
    if (v == '0) begin
      r = 0;
    end else if (int'(v) > limit) begin
      r = limit - 1;
    end else begin
      r = int'(v) - 1;
    end
    return r;
  endfunction

endpackage

// ===== sv/mfps_in_if.sv =====
interface mfps_in_if #(
  parameter int unsigned VALUE_BITS = mfps_pkg::VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

// ===== sv/mfps_out_if.sv =====
interface mfps_out_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [mfps_pkg::OUT_BITS-1:0] min_sum;

  modport source (output valid, output min_sum, input ready);
  modport sink (input valid, input min_sum, output ready);
endinterface

// ===== sv/min_falling_path_sum_unit.sv =====
// The frame's last element passes the compute stage, then its result enters a result register.
// Throughput: one element per cycle unless the input holds, frame ends included;
// one line-buffer read and write a cycle. Two result registers let the next frame run on while a
// beat waits; the input holds only while a stalled beat and a second result would fill both.
// Reset: position and sizes (1 x 1) cleared at once, running minimum set to the largest sum; the
// line buffer is not cleared, as every entry is written in a frame before its value is used.
module min_falling_path_sum_unit #(
  parameter int unsigned MAX_COLS   = mfps_pkg::MAX_COLS_DEF,
  parameter int unsigned VALUE_BITS = mfps_pkg::VALUE_BITS_DEF,
  parameter int unsigned SUM_BITS   = mfps_pkg::SUM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mfps_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [mfps_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  mfps_in_if.sink                           in_i,
  mfps_out_if.source                        out_o
);

  localparam int unsigned ADDR_BITS = mfps_pkg::addr_bits(MAX_COLS);

  // Fetch side: ctrl issues the line-buffer read when an element is accepted
  logic                         rd_en;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic [SUM_BITS-1:0]          rd_data;
  // Write-back side: datapath stores the fresh path sum in the cycle after the fetch
  logic                         wr_en;
  logic [ADDR_BITS-1:0]         wr_addr;
  logic [SUM_BITS-1:0]          wr_data;
  // Compute stage contents
  logic                         b_vld;
  mfps_pkg::item_flags_t        b_flags;
  logic [ADDR_BITS-1:0]         b_col;
  logic signed [VALUE_BITS-1:0] b_value;
  logic                         restart;
  logic                         out_busy;

  // Position tracking, size registers and the input handshake
  mfps_ctrl #(
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_i.valid),
    .in_value_i (in_i.cell_value),
    .in_ready_o (in_i.ready),
    .out_busy_i (out_busy),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .b_vld_o    (b_vld),
    .b_flags_o  (b_flags),
    .b_col_o    (b_col),
    .b_value_o  (b_value),
    .restart_o  (restart)
  );

  // Line buffer: path sums of the previous row, overwritten column by column
  mfps_ram #(
    .WIDTH(SUM_BITS),
    .DEPTH(MAX_COLS)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Three-way minimum, saturating add, running minimum and the two result registers
  mfps_dp #(
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .b_vld_i    (b_vld),
    .b_flags_i  (b_flags),
    .b_col_i    (b_col),
    .b_value_i  (b_value),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_sum_o  (out_o.min_sum),
    .out_busy_o (out_busy)
  );

endmodule

// ===== sv/mfps_ram.sv =====
module mfps_ram #(
  parameter int unsigned WIDTH = mfps_pkg::SUM_BITS_DEF,
  parameter int unsigned DEPTH = mfps_pkg::MAX_COLS_DEF,
  localparam int unsigned AW   = mfps_pkg::addr_bits(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and write of the same entry in one cycle returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mfps_ctrl.sv =====
module mfps_ctrl #(
  parameter int unsigned MAX_COLS   = mfps_pkg::MAX_COLS_DEF,
  parameter int unsigned VALUE_BITS = mfps_pkg::VALUE_BITS_DEF,
  localparam int unsigned ADDR_BITS = mfps_pkg::addr_bits(MAX_COLS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mfps_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [mfps_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic signed [VALUE_BITS-1:0]         in_value_i,
  output logic                                 in_ready_o,
  input  logic                                 out_busy_i,
  output logic                                 rd_en_o,
  output logic [ADDR_BITS-1:0]                 rd_addr_o,
  output logic                                 b_vld_o,
  output mfps_pkg::item_flags_t                b_flags_o,
  output logic [ADDR_BITS-1:0]                 b_col_o,
  output logic signed [VALUE_BITS-1:0]         b_value_o,
  output logic                                 restart_o
);

  logic [ADDR_BITS-1:0]          cols_last_q;
  logic [mfps_pkg::ROW_BITS-1:0] rows_last_q;
  logic [ADDR_BITS-1:0]          col_q, col_d;
  logic [mfps_pkg::ROW_BITS-1:0] row_q, row_d;
  logic                          b_vld_q;
  mfps_pkg::item_flags_t         b_flags_q, flags;
  logic [ADDR_BITS-1:0]          b_col_q;
  logic signed [VALUE_BITS-1:0]  b_value_q;
  logic                          accept, cfg_hit;

  // Hold off while both result slots may be taken next cycle
  assign in_ready_o = !out_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cfg_hit   = cfg_we_i && ((cfg_idx_i == mfps_pkg::REG_NUM_ROWS) ||
                                  (cfg_idx_i == mfps_pkg::REG_NUM_COLS));
  assign restart_o = cfg_hit;

  always_comb begin
    flags.first_row  = (row_q == '0);
    flags.last_row   = (row_q == rows_last_q);
    flags.has_left   = (col_q != '0);
    flags.last_col   = (col_q == cols_last_q);
    flags.has_right  = (col_q != cols_last_q);
    flags.single_col = (cols_last_q == '0);
  end

  // Fetch the right neighbour, or at row end the new head of the row
  assign rd_en_o   = accept;
  assign rd_addr_o = flags.last_col ? '0 : col_q + ADDR_BITS'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (flags.last_col) begin
        col_d = '0;
        row_d = flags.last_row ? '0 : row_q + mfps_pkg::ROW_BITS'(1);
      end else begin
        col_d = col_q + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_last_q <= '0;
      cols_last_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      b_vld_q     <= 1'b0;
      b_flags_q   <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == mfps_pkg::REG_NUM_ROWS)) begin
        rows_last_q <= mfps_pkg::ROW_BITS'(
            mfps_pkg::clamp_last(cfg_wdata_i, mfps_pkg::MAX_ROWS));
      end
      if (cfg_we_i && (cfg_idx_i == mfps_pkg::REG_NUM_COLS)) begin
        cols_last_q <= ADDR_BITS'(mfps_pkg::clamp_last(cfg_wdata_i, MAX_COLS));
      end
      col_q   <= col_d;
      row_q   <= row_d;
      b_vld_q <= accept;
      if (accept) begin
        b_flags_q <= flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q   <= col_q;
      b_value_q <= in_value_i;
    end
  end

  assign b_vld_o   = b_vld_q;
  assign b_flags_o = b_flags_q;
  assign b_col_o   = b_col_q;
  assign b_value_o = b_value_q;

endmodule

// ===== sv/mfps_dp.sv =====
module mfps_dp #(
  parameter int unsigned MAX_COLS   = mfps_pkg::MAX_COLS_DEF,
  parameter int unsigned VALUE_BITS = mfps_pkg::VALUE_BITS_DEF,
  parameter int unsigned SUM_BITS   = mfps_pkg::SUM_BITS_DEF,
  localparam int unsigned ADDR_BITS = mfps_pkg::addr_bits(MAX_COLS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 restart_i,
  input  logic                                 b_vld_i,
  input  mfps_pkg::item_flags_t                b_flags_i,
  input  logic [ADDR_BITS-1:0]                 b_col_i,
  input  logic signed [VALUE_BITS-1:0]         b_value_i,
  input  logic                                 rd_en_i,
  input  logic [ADDR_BITS-1:0]                 rd_addr_i,
  input  logic [SUM_BITS-1:0]                  rd_data_i,
  output logic                                 wr_en_o,
  output logic [ADDR_BITS-1:0]                 wr_addr_o,
  output logic [SUM_BITS-1:0]                  wr_data_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mfps_pkg::OUT_BITS-1:0] out_sum_o,
  output logic                                 out_busy_o
);

  localparam int unsigned EXT_BITS  = ((VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS) + 1;
  localparam int unsigned WIDE_BITS = (SUM_BITS > mfps_pkg::OUT_BITS) ?
                                      SUM_BITS : mfps_pkg::OUT_BITS;
  localparam logic signed [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SMIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic                                 fwd_hit_q;
  logic signed [SUM_BITS-1:0]           fwd_data_q;
  logic signed [SUM_BITS-1:0]           left_q, mid_q;
  logic signed [SUM_BITS-1:0]           run_q;
  logic [1:0]                           cnt_q, cnt_d;
  logic signed [mfps_pkg::OUT_BITS-1:0] head_q, head_d, skid_q, skid_d, push_data;
  logic signed [SUM_BITS-1:0]           right, best, addend, sum, run_min;
  logic signed [EXT_BITS-1:0]           ext_sum;
  logic signed [WIDE_BITS-1:0]          run_wide;
  logic                                 result, pop;

  // Catch a fetch that collides with the write-back in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= rd_en_i && wr_en_o && (rd_addr_i == wr_addr_o);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data_o;
  end

  assign right = fwd_hit_q ? fwd_data_q : rd_data_i;

  always_comb begin
    best = mid_q;
    if (b_flags_i.has_left && (left_q < best)) begin
      best = left_q;
    end
    if (b_flags_i.has_right && (right < best)) begin
      best = right;
    end
  end

  assign addend  = b_flags_i.first_row ? '0 : best;
  assign ext_sum = EXT_BITS'(b_value_i) + EXT_BITS'(addend);

  always_comb begin
    if (ext_sum > EXT_BITS'(SMAX)) begin
      sum = SMAX;
    end else if (ext_sum < EXT_BITS'(SMIN)) begin
      sum = SMIN;
    end else begin
      sum = ext_sum[SUM_BITS-1:0];
    end
  end

  assign wr_en_o   = b_vld_i;
  assign wr_addr_o = b_col_i;
  assign wr_data_o = sum;

  // Slide the previous-row window; at row end load the new row head
  always_ff @(posedge clk_i) begin
    if (b_vld_i) begin
      left_q <= mid_q;
      if (b_flags_i.last_col && b_flags_i.single_col) begin
        mid_q <= sum;
      end else begin
        mid_q <= right;
      end
    end
  end

  assign run_min  = (sum < run_q) ? sum : run_q;
  assign run_wide = WIDE_BITS'(run_min);
  assign result   = b_vld_i && b_flags_i.last_row && b_flags_i.last_col;

  // Two result slots: head is offered, skid holds a second beat behind a stalled head
  assign push_data = run_wide[mfps_pkg::OUT_BITS-1:0];
  assign pop       = (cnt_q != 2'd0) && out_ready_i;
  assign cnt_d     = cnt_q + {1'b0, result} - {1'b0, pop};

  always_comb begin
    head_d = head_q;
    skid_d = skid_q;
    if (pop) begin
      if (cnt_q == 2'd2) begin
        head_d = skid_q;
        if (result) begin
          skid_d = push_data;
        end
      end else if (result) begin
        head_d = push_data;
      end
    end else if (result) begin
      if (cnt_q == 2'd0) begin
        head_d = push_data;
      end else begin
        skid_d = push_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= SMAX;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (restart_i || result) begin
        run_q <= SMAX;
      end else if (b_vld_i && b_flags_i.last_row) begin
        run_q <= run_min;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_sum_o   = head_q;
  // Both slots taken after this edge: an element taken now could not place its result
  assign out_busy_o  = cnt_d[1];

endmodule

// ===== sv/mfps_chk.sv =====
module mfps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  mfps_in_if.sink    in_i,
  mfps_out_if.source out_o
);

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.min_sum))
    else $error("result beat changed while stalled");

  // Handshake outputs never go unknown once out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_i.ready, out_o.valid}))
    else $error("unknown handshake output");

  // A fresh result beat is preceded by an accepted element, through the compute stage and the result register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(in_i.valid && in_i.ready, 2))
    else $error("result beat without a preceding element");

endmodule

bind min_falling_path_sum_unit mfps_chk u_mfps_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_i  (in_i),
  .out_o (out_o)
);
